### hdl/mect_pkg.sv
// ============================================================================
// mect_pkg
// Shared types and constants of the motion-excited colour trail: the pixel
// item structs, the per-pixel state record, register indexes and reset values.
// ============================================================================
`default_nettype none

package mect_pkg;

  // Frame size and the width of a pixel position.
  localparam int unsigned FRAME_PIXELS_DEF = 307200;
  localparam int unsigned IDX_W            = 19;

  // Output ranges of luma and chroma.
  localparam logic [7:0] LUMA_MIN   = 8'd0;
  localparam logic [7:0] LUMA_MAX   = 8'd255;
  localparam logic [7:0] CHROMA_MIN = 8'd0;
  localparam logic [7:0] CHROMA_MAX = 8'd255;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_MODE        = 3'd0,
    CFG_OVERLAY_OPACITY    = 3'd1,
    CFG_TRAIL_PERSISTENCE  = 3'd2,
    CFG_MOTION_PERSISTENCE = 3'd3,
    CFG_MOTION_GAIN        = 3'd4,
    CFG_MOTION_CUTOFF      = 3'd5,
    CFG_ADAPTATION_RATE    = 3'd6,
    CFG_STROBE_WORD        = 3'd7
  } cfg_idx_t;

  // Output modes; the spare code shows the full trail.
  localparam logic [1:0] MODE_TRAIL   = 2'd0;
  localparam logic [1:0] MODE_OVERLAY = 2'd1;
  localparam logic [1:0] MODE_GREY    = 2'd2;

  // Register reset values.
  localparam logic [1:0]  RST_OUTPUT_MODE        = MODE_TRAIL;
  localparam logic [7:0]  RST_OVERLAY_OPACITY    = 8'd150;
  localparam logic [7:0]  RST_TRAIL_PERSISTENCE  = 8'd200;
  localparam logic [7:0]  RST_MOTION_PERSISTENCE = 8'd180;
  localparam logic [10:0] RST_MOTION_GAIN        = 11'd256;
  localparam logic [7:0]  RST_MOTION_CUTOFF      = 8'd0;
  localparam logic [8:0]  RST_ADAPTATION_RATE    = 9'd106;
  localparam logic [24:0] RST_STROBE_WORD        = 25'd14319756;

  // Arithmetic constants.
  localparam logic [7:0]  FLASH_ON        = 8'd255;
  localparam logic [7:0]  FLASH_OFF       = 8'd192;
  localparam logic [7:0]  CHROMA_ZERO     = 8'd128;
  localparam logic [7:0]  SEED_EXCITATION = 8'd64;
  localparam logic [7:0]  FULL_SCALE      = 8'd255;
  localparam logic [8:0]  UNITY_Q8        = 9'd256;
  localparam logic [10:0] GAIN_MAX        = 11'd1024;
  localparam int unsigned FLASH_BIT       = 24;

  // Input item.
  typedef struct packed {
    logic [7:0]       pixel_y;
    logic [7:0]       pixel_u;
    logic [7:0]       pixel_v;
    logic [IDX_W-1:0] pixel_index;
    logic             seed_frame;
  } pix_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_y;
    logic [7:0] out_u;
    logic [7:0] out_v;
  } pix_out_t;

  // Per-pixel state record held in the frame memory.
  typedef struct packed {
    logic [7:0] trail_luma;
    logic [7:0] background_luma;
    logic [7:0] trail_cb;
    logic [7:0] trail_cr;
    logic [7:0] excitation_level;
  } px_state_t;

  localparam px_state_t STATE_RESET = '{
    trail_luma:       8'd0,
    background_luma:  8'd0,
    trail_cb:         CHROMA_ZERO,
    trail_cr:         CHROMA_ZERO,
    excitation_level: 8'd0
  };

endpackage

`default_nettype wire

### hdl/motion_excited_color_trail.sv
// ============================================================================
// motion_excited_color_trail
// Per-pixel YUV motion trail with a leaky excitation level, strobe colour
// blending and three output views, built as a six-stage pipeline around a
// frame-sized state memory.
// ============================================================================
// Path: an accepted item passes stages 1 to 6, then the output register.
// Throughput: one item per cycle while the output is not stalled; an in-range
// item whose pixel_index matches one in the pipeline waits for its write-back.
// Reset: the configuration registers and valid bits return to their reset values,
// then a clearing pass writes the reset state to every memory row, one row a cycle;
// no item is accepted meanwhile, register writes are.
`default_nettype none

module motion_excited_color_trail #(
  parameter int unsigned FRAME_PIXELS = mect_pkg::FRAME_PIXELS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Configuration write port
  input  wire                              cfg_wr_en,
  input  wire  [mect_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mect_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  // Input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  mect_pkg::pix_in_t                in_data,
  // Result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output mect_pkg::pix_out_t               out_data
);

  localparam int unsigned IDX_W     = mect_pkg::IDX_W;
  localparam int unsigned MEM_DEPTH = (FRAME_PIXELS > (2 ** IDX_W)) ? (2 ** IDX_W)
                                                                     : FRAME_PIXELS;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  // Record carried from stage to stage; later stages reuse earlier fields.
  typedef struct packed {
    logic              rng;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        py;
    logic [7:0]        pu;
    logic [7:0]        pv;
    logic [7:0]        motion;
    logic [7:0]        exc;
    logic [7:0]        vy;
    logic signed [7:0] vuc;
    logic signed [7:0] vvc;
    logic [7:0]        bg;
    logic [7:0]        tl;
    logic [7:0]        cb;
    logic [7:0]        cr;
  } pipe_t;

  // Clamp a signed value to an unsigned 8-bit range.
  function automatic logic [7:0] clamp8(input logic signed [9:0] v,
                                        input logic [7:0] lo,
                                        input logic [7:0] hi);
    logic signed [9:0] lo_s;
    logic signed [9:0] hi_s;
    lo_s = $signed({2'b00, lo});
    hi_s = $signed({2'b00, hi});
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end
    return v[7:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  cfg_mode_r;
  logic [7:0]  cfg_opacity_r;
  logic [7:0]  cfg_tpers_r;
  logic [7:0]  cfg_mpers_r;
  logic [10:0] cfg_gain_r;
  logic [7:0]  cfg_cutoff_r;
  logic [8:0]  cfg_adapt_r;
  logic [24:0] cfg_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r    <= mect_pkg::RST_OUTPUT_MODE;
      cfg_opacity_r <= mect_pkg::RST_OVERLAY_OPACITY;
      cfg_tpers_r   <= mect_pkg::RST_TRAIL_PERSISTENCE;
      cfg_mpers_r   <= mect_pkg::RST_MOTION_PERSISTENCE;
      cfg_gain_r    <= mect_pkg::RST_MOTION_GAIN;
      cfg_cutoff_r  <= mect_pkg::RST_MOTION_CUTOFF;
      cfg_adapt_r   <= mect_pkg::RST_ADAPTATION_RATE;
      cfg_strobe_r  <= mect_pkg::RST_STROBE_WORD;
    end else if (cfg_wr_en) begin
      unique case (mect_pkg::cfg_idx_t'(cfg_index))
        mect_pkg::CFG_OUTPUT_MODE:        cfg_mode_r    <= cfg_wr_data[1:0];
        mect_pkg::CFG_OVERLAY_OPACITY:    cfg_opacity_r <= cfg_wr_data[7:0];
        mect_pkg::CFG_TRAIL_PERSISTENCE:  cfg_tpers_r   <= cfg_wr_data[7:0];
        mect_pkg::CFG_MOTION_PERSISTENCE: cfg_mpers_r   <= cfg_wr_data[7:0];
        mect_pkg::CFG_MOTION_GAIN:        cfg_gain_r    <= cfg_wr_data[10:0];
        mect_pkg::CFG_MOTION_CUTOFF:      cfg_cutoff_r  <= cfg_wr_data[7:0];
        mect_pkg::CFG_ADAPTATION_RATE:    cfg_adapt_r   <= cfg_wr_data[8:0];
        mect_pkg::CFG_STROBE_WORD:        cfg_strobe_r  <= cfg_wr_data[24:0];
        default: ;
      endcase
    end
  end

  // Derived settings: gain and adaptation rate are saturated to their ranges.
  logic [10:0] gain_c;
  logic [8:0]  adapt_c;
  logic [8:0]  adapt_inv;
  logic [7:0]  flash_c;
  logic [8:0]  op_q;
  logic [8:0]  op_qinv;

  always_comb begin
    gain_c = (cfg_gain_r > mect_pkg::GAIN_MAX) ? mect_pkg::GAIN_MAX : cfg_gain_r;
    if (cfg_adapt_r == 9'd0) begin
      adapt_c = 9'd1;
    end else if (cfg_adapt_r > mect_pkg::UNITY_Q8) begin
      adapt_c = mect_pkg::UNITY_Q8;
    end else begin
      adapt_c = cfg_adapt_r;
    end
    adapt_inv = mect_pkg::UNITY_Q8 - adapt_c;
    flash_c   = cfg_strobe_r[mect_pkg::FLASH_BIT] ? mect_pkg::FLASH_ON
                                                  : mect_pkg::FLASH_OFF;
    // Opacity rescaled from 0..255 to 0..256 with rounding up at the midpoint.
    op_q    = {1'b0, cfg_opacity_r} + {8'd0, cfg_opacity_r[7]};
    op_qinv = mect_pkg::UNITY_Q8 - op_q;
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  mect_pkg::pix_in_t s1_in_r;
  logic              s1_rng_r;
  logic [6:2]        v_r;
  pipe_t             s2_r, s3_r, s4_r, s5_r, s6_r;
  pipe_t             s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt;
  logic              out_valid_r;
  mect_pkg::pix_out_t out_data_r;
  mect_pkg::pix_out_t out_nxt;
  logic [7:1]        rdy;
  logic              in_rng;
  logic              hazard;
  logic              in_acc;
  logic              wb_en;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_addr_r;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    rdy[7] = !out_valid_r || !out_stall;
    for (int k = 6; k >= 2; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    rdy[1] = !s1_valid_r || rdy[2];
  end

  // An item may not read state that an earlier item has yet to write back.
  always_comb begin
    in_rng = (32'(in_data.pixel_index) < FRAME_PIXELS);
    hazard = in_rng && (
      (s1_valid_r && s1_rng_r && (s1_in_r.pixel_index == in_data.pixel_index)) ||
      (v_r[2] && s2_r.rng && (s2_r.idx == in_data.pixel_index)) ||
      (v_r[3] && s3_r.rng && (s3_r.idx == in_data.pixel_index)) ||
      (v_r[4] && s4_r.rng && (s4_r.idx == in_data.pixel_index)) ||
      (v_r[5] && s5_r.rng && (s5_r.idx == in_data.pixel_index)) ||
      (v_r[6] && s6_r.rng && (s6_r.idx == in_data.pixel_index)));
  end

  assign in_stall = clr_busy_r || !rdy[1] || hazard;
  assign in_acc   = in_valid && !in_stall;
  assign wb_en    = v_r[6] && s6_r.rng && rdy[7];

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame state memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  mect_pkg::px_state_t mem [MEM_DEPTH];
  mect_pkg::px_state_t rdata_r;
  mect_pkg::px_state_t wb_state;

  assign wb_state = '{
    trail_luma:       s6_r.tl,
    background_luma:  s6_r.bg,
    trail_cb:         s6_r.cb,
    trail_cr:         s6_r.cr,
    excitation_level: s6_r.exc
  };

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= mect_pkg::STATE_RESET;
    end else if (wb_en) begin
      mem[s6_r.idx[AW-1:0]] <= wb_state;
    end
    if (rdy[1]) begin
      rdata_r <= mem[in_data.pixel_index[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: state selection, motion excess, trail decay, background update
  // --------------------------------------------------------------------------
  mect_pkg::px_state_t st_sel;
  logic [7:0]          diff;
  logic [15:0]         m_vy;
  logic signed [8:0]   cb_c1;
  logic signed [8:0]   cr_c1;
  logic signed [8:0]   tpers_s;
  logic signed [16:0]  m_vu;
  logic signed [16:0]  m_vv;
  logic [16:0]         m_bg;

  always_comb begin
    // Seeding starts this pixel from a fresh state before the usual update.
    if (s1_in_r.seed_frame) begin
      st_sel = '{
        trail_luma:       8'd0,
        background_luma:  s1_in_r.pixel_y,
        trail_cb:         mect_pkg::CHROMA_ZERO,
        trail_cr:         mect_pkg::CHROMA_ZERO,
        excitation_level: mect_pkg::SEED_EXCITATION
      };
    end else begin
      st_sel = rdata_r;
    end
    diff = (s1_in_r.pixel_y > st_sel.background_luma)
         ? (s1_in_r.pixel_y - st_sel.background_luma)
         : (st_sel.background_luma - s1_in_r.pixel_y);
    m_vy    = st_sel.trail_luma * cfg_tpers_r;
    cb_c1   = $signed({1'b0, st_sel.trail_cb}) - 9'sd128;
    cr_c1   = $signed({1'b0, st_sel.trail_cr}) - 9'sd128;
    tpers_s = $signed({1'b0, cfg_tpers_r});
    m_vu    = cb_c1 * tpers_s;
    m_vv    = cr_c1 * tpers_s;
    m_bg    = st_sel.background_luma * adapt_inv + s1_in_r.pixel_y * adapt_c;

    s2_nxt        = '0;
    s2_nxt.rng    = s1_rng_r;
    s2_nxt.idx    = s1_in_r.pixel_index;
    s2_nxt.py     = s1_in_r.pixel_y;
    s2_nxt.pu     = s1_in_r.pixel_u;
    s2_nxt.pv     = s1_in_r.pixel_v;
    s2_nxt.motion = (diff > cfg_cutoff_r) ? (diff - cfg_cutoff_r) : 8'd0;
    s2_nxt.exc    = st_sel.excitation_level;
    s2_nxt.vy     = m_vy[15:8];
    // Arithmetic shift of the product: rounds toward minus infinity.
    s2_nxt.vuc    = $signed(m_vu[15:8]);
    s2_nxt.vvc    = $signed(m_vv[15:8]);
    s2_nxt.bg     = m_bg[15:8];
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain on the motion excess, saturated at full scale
  // --------------------------------------------------------------------------
  logic [18:0] m_raw;

  always_comb begin
    m_raw  = s2_r.motion * gain_c;
    s3_nxt = s2_r;
    s3_nxt.motion = (m_raw[18:8] > 11'(mect_pkg::FULL_SCALE)) ? mect_pkg::FULL_SCALE
                                                               : m_raw[15:8];
  end

  // --------------------------------------------------------------------------
  // Stage 3: leaky excitation mix
  // --------------------------------------------------------------------------
  logic [8:0]  mpers_inv;
  logic [16:0] m_mix;

  always_comb begin
    mpers_inv  = mect_pkg::UNITY_Q8 - {1'b0, cfg_mpers_r};
    m_mix      = s3_r.exc * cfg_mpers_r + s3_r.motion * mpers_inv;
    s4_nxt     = s3_r;
    s4_nxt.exc = m_mix[15:8];
  end

  // --------------------------------------------------------------------------
  // Stage 4: strobe factor on the excitation (cannot exceed full scale)
  // --------------------------------------------------------------------------
  logic [15:0] m_flash;

  always_comb begin
    m_flash    = s4_r.exc * flash_c;
    s5_nxt     = s4_r;
    s5_nxt.exc = m_flash[15:8];
  end

  // --------------------------------------------------------------------------
  // Stage 5: blend the strobe colour into the decayed trail
  // --------------------------------------------------------------------------
  logic [7:0]         inv5;
  logic [15:0]        m_ny;
  logic signed [8:0]  inv5_s;
  logic signed [8:0]  ex5_s;
  logic signed [8:0]  su_c;
  logic signed [8:0]  sv_c;
  logic signed [17:0] m_nu;
  logic signed [17:0] m_nv;
  logic signed [9:0]  nu_w;
  logic signed [9:0]  nv_w;

  always_comb begin
    inv5   = mect_pkg::FULL_SCALE - s5_r.exc;
    m_ny   = s5_r.vy * inv5 + cfg_strobe_r[7:0] * s5_r.exc;
    inv5_s = $signed({1'b0, inv5});
    ex5_s  = $signed({1'b0, s5_r.exc});
    su_c   = $signed({1'b0, cfg_strobe_r[15:8]}) - 9'sd128;
    sv_c   = $signed({1'b0, cfg_strobe_r[23:16]}) - 9'sd128;
    m_nu   = s5_r.vuc * inv5_s + su_c * ex5_s;
    m_nv   = s5_r.vvc * inv5_s + sv_c * ex5_s;
    nu_w   = $signed(m_nu[17:8]) + 10'sd128;
    nv_w   = $signed(m_nv[17:8]) + 10'sd128;

    s6_nxt    = s5_r;
    s6_nxt.tl = clamp8($signed({2'b00, m_ny[15:8]}), mect_pkg::LUMA_MIN,
                       mect_pkg::LUMA_MAX);
    s6_nxt.cb = clamp8(nu_w, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX);
    s6_nxt.cr = clamp8(nv_w, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX);
  end

  // --------------------------------------------------------------------------
  // Stage 6: write-back and output view
  // --------------------------------------------------------------------------
  logic [16:0]        m_oy;
  logic signed [8:0]  pu_c;
  logic signed [8:0]  pv_c;
  logic signed [8:0]  cb_c6;
  logic signed [8:0]  cr_c6;
  logic signed [9:0]  q_s;
  logic signed [9:0]  qinv_s;
  logic signed [17:0] m_ou;
  logic signed [17:0] m_ov;
  logic signed [9:0]  ou_w;
  logic signed [9:0]  ov_w;

  always_comb begin
    m_oy   = s6_r.py * op_qinv + s6_r.tl * op_q + 17'd128;
    pu_c   = $signed({1'b0, s6_r.pu}) - 9'sd128;
    pv_c   = $signed({1'b0, s6_r.pv}) - 9'sd128;
    cb_c6  = $signed({1'b0, s6_r.cb}) - 9'sd128;
    cr_c6  = $signed({1'b0, s6_r.cr}) - 9'sd128;
    q_s    = $signed({1'b0, op_q});
    qinv_s = $signed({1'b0, op_qinv});
    m_ou   = pu_c * qinv_s + cb_c6 * q_s + 18'sd128;
    m_ov   = pv_c * qinv_s + cr_c6 * q_s + 18'sd128;
    ou_w   = $signed(m_ou[17:8]) + 10'sd128;
    ov_w   = $signed(m_ov[17:8]) + 10'sd128;

    if (!s6_r.rng) begin
      // Positions beyond the frame pass through untouched.
      out_nxt = '{out_y: s6_r.py, out_u: s6_r.pu, out_v: s6_r.pv};
    end else begin
      case (cfg_mode_r)
        mect_pkg::MODE_GREY: begin
          out_nxt.out_y = clamp8($signed({1'b0, s6_r.exc, 1'b0}), mect_pkg::LUMA_MIN,
                                 mect_pkg::LUMA_MAX);
          out_nxt.out_u = mect_pkg::CHROMA_ZERO;
          out_nxt.out_v = mect_pkg::CHROMA_ZERO;
        end
        mect_pkg::MODE_OVERLAY: begin
          out_nxt.out_y = m_oy[15:8];
          out_nxt.out_u = clamp8(ou_w, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX);
          out_nxt.out_v = clamp8(ov_w, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX);
        end
        default: begin
          out_nxt = '{out_y: s6_r.tl, out_u: s6_r.cb, out_v: s6_r.cr};
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers: valid bits under reset, payload without
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) begin
        s1_valid_r <= in_acc;
      end
      if (rdy[2]) begin
        v_r[2] <= s1_valid_r;
      end
      for (int k = 3; k <= 6; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy[7]) begin
        out_valid_r <= v_r[6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_in_r  <= in_data;
      s1_rng_r <= in_rng;
    end
    if (rdy[2]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[3]) begin
      s3_r <= s3_nxt;
    end
    if (rdy[4]) begin
      s4_r <= s4_nxt;
    end
    if (rdy[5]) begin
      s5_r <= s5_nxt;
    end
    if (rdy[6]) begin
      s6_r <= s6_nxt;
    end
    if (rdy[7]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The pipeline stays empty while the memory is being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(s1_valid_r || (|v_r) || out_valid_r))
    else $error("pipeline holds an item during the clearing pass");

  // The clearing pass ends only after the last row.
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == LAST_ADDR))
    else $error("clearing pass ended early");

  // No item reads a row in the same cycle that row is written back.
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_en && in_acc && in_rng) |-> (in_data.pixel_index != s6_r.idx))
    else $error("read of a row under write-back");

  // A held result keeps the item behind it in the last stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && v_r[6]) |=> (v_r[6] && $stable(s6_r.idx)))
    else $error("last stage lost its item under stall");

endmodule

`default_nettype wire

### bench/tb_motion_excited_color_trail.sv
// ============================================================================
// tb_motion_excited_color_trail
// Self-checking bench for the motion-excited colour trail. A local predictor
// tracks the per-pixel trail, background and excitation state together with
// the register file. Every accepted result is compared with the oldest
// expected pixel. The stimulus covers seeding, out-of-range positions, all
// output views, register extremes and frame-like sequences with random
// content. Both channels idle at random, and one long output hold-off fills
// the pipeline.
// ============================================================================
`default_nettype none

module tb_motion_excited_color_trail;

  localparam int FRAME_PIXELS     = mect_pkg::FRAME_PIXELS_DEF;
  localparam int INDEX_W          = mect_pkg::IDX_W;
  localparam int INDEX_SPAN       = 1 << INDEX_W;
  localparam int POOL_SIZE        = 16;
  localparam int PHASES           = 10;
  localparam int FRAMES_PER_PHASE = 9;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 12;
  localparam int MAX_REPORTS      = 50;
  localparam int RUN_LIMIT_CYCLES = 3000000;

  // Spare output mode code, which shows the full trail.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  mect_pkg::cfg_idx_t cfg_index;
  logic [mect_pkg::CFG_DATA_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  mect_pkg::pix_in_t  in_data;
  logic               out_valid;
  logic               out_stall;
  mect_pkg::pix_out_t out_data;

  motion_excited_color_trail #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Register copies held by the predictor.
  logic [1:0]  cur_mode;
  logic [7:0]  cur_opacity;
  logic [7:0]  cur_trail_decay;
  logic [7:0]  cur_motion_decay;
  logic [10:0] cur_gain;
  logic [7:0]  cur_cutoff;
  logic [8:0]  cur_rate;
  logic [24:0] cur_strobe;

  // Per-pixel state; a position never touched holds the reset record.
  mect_pkg::px_state_t trail_state [int];
  mect_pkg::pix_out_t  expected_pixels [$];

  int error_count;
  int gap_pct;
  int stall_pct;
  bit hold_off_req;

  // Positions revisited frame after frame, and the scene luma at each.
  int pool [POOL_SIZE];
  int scene_luma [POOL_SIZE];

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int fit(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Division by 256 rounding towards minus infinity.
  function automatic int floor_q8(input int x);
    return x >>> 8;
  endfunction

  function automatic int mix_chroma(input int a, input int b, input int q);
    return fit(floor_q8((a - 128) * (256 - q) + (b - 128) * q + 128) + 128,
               mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX);
  endfunction

  function automatic mect_pkg::pix_out_t predict_trail(input mect_pkg::pix_in_t px);
    mect_pkg::px_state_t st;
    mect_pkg::pix_out_t  res;
    int idx, py, pu, pv;
    int tl, cb, cr, exc, bg;
    int pers, ep, gain, adapt, flash, sy, su, sv;
    int diff, vy, vuc, vvc, over, raw, ex, inv, ny, nu, nv, q;
    idx = px.pixel_index;
    py  = px.pixel_y;
    pu  = px.pixel_u;
    pv  = px.pixel_v;
    // Positions beyond the frame pass the pixel through untouched.
    if (idx >= FRAME_PIXELS) begin
      res.out_y = px.pixel_y;
      res.out_u = px.pixel_u;
      res.out_v = px.pixel_v;
      return res;
    end
    st = trail_state.exists(idx) ? trail_state[idx] : mect_pkg::STATE_RESET;
    if (px.seed_frame) begin
      st.trail_luma       = 8'd0;
      st.background_luma  = px.pixel_y;
      st.trail_cb         = mect_pkg::CHROMA_ZERO;
      st.trail_cr         = mect_pkg::CHROMA_ZERO;
      st.excitation_level = mect_pkg::SEED_EXCITATION;
    end
    tl  = st.trail_luma;
    bg  = st.background_luma;
    cb  = st.trail_cb;
    cr  = st.trail_cr;
    exc = st.excitation_level;

    pers  = cur_trail_decay;
    ep    = cur_motion_decay;
    gain  = (cur_gain > mect_pkg::GAIN_MAX) ? mect_pkg::GAIN_MAX : cur_gain;
    adapt = fit(cur_rate, 1, 256);
    flash = cur_strobe[mect_pkg::FLASH_BIT] ? mect_pkg::FLASH_ON : mect_pkg::FLASH_OFF;
    sy    = cur_strobe[7:0];
    su    = cur_strobe[15:8];
    sv    = cur_strobe[23:16];

    // Decayed trail colour.
    diff = (py > bg) ? py - bg : bg - py;
    vy   = tl * pers / 256;
    vuc  = floor_q8((cb - 128) * pers);
    vvc  = floor_q8((cr - 128) * pers);

    // Motion excess drives the leaky excitation, then the strobe factor.
    over = diff - int'(cur_cutoff);
    if (over < 0) over = 0;
    raw = over * gain / 256;
    if (raw > 255) raw = 255;
    ex = (exc * ep + raw * (256 - ep)) / 256;
    ex = ex * flash / 256;
    if (ex > 255) ex = 255;

    // Strobe colour blended into the trail by the excitation.
    inv = 255 - ex;
    ny  = (vy * inv + sy * ex) / 256;
    nu  = floor_q8(vuc * inv + (su - 128) * ex) + 128;
    nv  = floor_q8(vvc * inv + (sv - 128) * ex) + 128;

    st.excitation_level = 8'(ex);
    st.trail_luma       = 8'(fit(ny, mect_pkg::LUMA_MIN, mect_pkg::LUMA_MAX));
    st.trail_cb         = 8'(fit(nu, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX));
    st.trail_cr         = 8'(fit(nv, mect_pkg::CHROMA_MIN, mect_pkg::CHROMA_MAX));
    st.background_luma  = 8'((bg * (256 - adapt) + py * adapt) / 256);
    trail_state[idx]    = st;

    if (cur_mode == mect_pkg::MODE_GREY) begin
      res.out_y = 8'(fit(ex * 2, mect_pkg::LUMA_MIN, mect_pkg::LUMA_MAX));
      res.out_u = mect_pkg::CHROMA_ZERO;
      res.out_v = mect_pkg::CHROMA_ZERO;
    end else if (cur_mode == mect_pkg::MODE_OVERLAY) begin
      q = (int'(cur_opacity) * 256 + 127) / 255;
      res.out_y = 8'((py * (256 - q) + int'(st.trail_luma) * q + 128) / 256);
      res.out_u = 8'(mix_chroma(pu, st.trail_cb, q));
      res.out_v = 8'(mix_chroma(pv, st.trail_cr, q));
    end else begin
      res.out_y = st.trail_luma;
      res.out_u = st.trail_cb;
      res.out_v = st.trail_cr;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic mect_pkg::pix_in_t make_pixel(input int y, input int u, input int v,
                                                   input int idx, input bit seed);
    mect_pkg::pix_in_t px;
    px.pixel_y     = 8'(y);
    px.pixel_u     = 8'(u);
    px.pixel_v     = 8'(v);
    px.pixel_index = INDEX_W'(idx);
    px.seed_frame  = seed;
    return px;
  endfunction

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // Scene luma at a pool position: small jitter, with a jump now and then.
  function automatic mect_pkg::pix_in_t scene_pixel(input int slot, input bit seed);
    int y;
    if ($urandom_range(3) == 0) scene_luma[slot] = $urandom_range(255);
    y = fit(scene_luma[slot] + int'($urandom_range(16)) - 8, 0, 255);
    return make_pixel(y, $urandom_range(255), $urandom_range(255), pool[slot], seed);
  endfunction

  // Any position at all, with a random seed flag.
  function automatic mect_pkg::pix_in_t noise_pixel();
    int idx;
    idx = $urandom_range(1) ? $urandom_range(INDEX_SPAN - 1)
                            : pool[$urandom_range(POOL_SIZE - 1)];
    return make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      idx, $urandom_range(1));
  endfunction

  // Pool with both frame ends and repeated neighbours to provoke hazards.
  task automatic new_pool();
    int k;
    pool[0] = 0;
    pool[1] = FRAME_PIXELS - 1;
    pool[2] = FRAME_PIXELS - 1;
    for (k = 3; k < POOL_SIZE; k++) begin
      pool[k] = ($urandom_range(3) == 0) ? pool[k-1] : $urandom_range(FRAME_PIXELS - 1);
    end
    for (k = 0; k < POOL_SIZE; k++) scene_luma[k] = $urandom_range(255);
  endtask

  // --------------------------------------------------------------------------
  // Channel and register tasks
  // --------------------------------------------------------------------------

  // Offer one item, wait for it to be taken, and record its expected result.
  task automatic send_pixel(input mect_pkg::pix_in_t px);
    int gap;
    @(negedge clk);
    gap = ($urandom_range(99) < gap_pct) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(predict_trail(px));
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Let every outstanding item come back before touching the registers.
  task automatic wait_drained();
    sender_idle();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mect_pkg::cfg_idx_t idx,
                           input logic [mect_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    case (idx)
      mect_pkg::CFG_OUTPUT_MODE:        cur_mode         = val[1:0];
      mect_pkg::CFG_OVERLAY_OPACITY:    cur_opacity      = val[7:0];
      mect_pkg::CFG_TRAIL_PERSISTENCE:  cur_trail_decay  = val[7:0];
      mect_pkg::CFG_MOTION_PERSISTENCE: cur_motion_decay = val[7:0];
      mect_pkg::CFG_MOTION_GAIN:        cur_gain         = val[10:0];
      mect_pkg::CFG_MOTION_CUTOFF:      cur_cutoff       = val[7:0];
      mect_pkg::CFG_ADAPTATION_RATE:    cur_rate         = val[8:0];
      mect_pkg::CFG_STROBE_WORD:        cur_strobe       = val[24:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input int mode, input int opacity, input int tpers,
                             input int mpers, input int gain, input int cutoff,
                             input int rate, input int strobe);
    write_reg(mect_pkg::CFG_OUTPUT_MODE, mode);
    write_reg(mect_pkg::CFG_OVERLAY_OPACITY, opacity);
    write_reg(mect_pkg::CFG_TRAIL_PERSISTENCE, tpers);
    write_reg(mect_pkg::CFG_MOTION_PERSISTENCE, mpers);
    write_reg(mect_pkg::CFG_MOTION_GAIN, gain);
    write_reg(mect_pkg::CFG_MOTION_CUTOFF, cutoff);
    write_reg(mect_pkg::CFG_ADAPTATION_RATE, rate);
    write_reg(mect_pkg::CFG_STROBE_WORD, strobe);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Seeding at both frame ends with extreme samples, back to back on one
  // position, and a position left in its reset state.
  task automatic test_seeding();
    send_pixel(make_pixel(255, 0, 255, 0, 1'b1));
    send_pixel(make_pixel(0, 255, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 255, 0, FRAME_PIXELS - 1, 1'b1));
    send_pixel(make_pixel(255, 255, 255, FRAME_PIXELS - 1, 1'b0));
    send_pixel(make_pixel(128, 128, 128, 1, 1'b0));
  endtask

  // Positions beyond the frame pass straight through.
  task automatic test_out_of_range();
    send_pixel(make_pixel(17, 200, 3, FRAME_PIXELS, 1'b0));
    send_pixel(make_pixel(255, 0, 255, INDEX_SPAN - 1, 1'b1));
    send_pixel(make_pixel(0, 255, 0, $urandom_range(INDEX_SPAN - 1, FRAME_PIXELS), 1'b0));
  endtask

  // Each output view, including the spare mode code and both opacity ends.
  task automatic test_output_modes();
    logic [1:0] modes [4];
    int m;
    modes = '{mect_pkg::MODE_TRAIL, mect_pkg::MODE_OVERLAY, mect_pkg::MODE_GREY,
              MODE_SPARE};
    for (m = 0; m < 4; m++) begin
      wait_drained();
      write_reg(mect_pkg::CFG_OUTPUT_MODE, modes[m]);
      send_pixel(make_pixel(240, 30, 220, 0, 1'b0));
      send_pixel(make_pixel(5, 250, 10, 2, m == 0));
    end
    wait_drained();
    write_reg(mect_pkg::CFG_OUTPUT_MODE, mect_pkg::MODE_OVERLAY);
    write_reg(mect_pkg::CFG_OVERLAY_OPACITY, 0);
    send_pixel(make_pixel(200, 10, 240, 0, 1'b0));
    wait_drained();
    write_reg(mect_pkg::CFG_OVERLAY_OPACITY, 255);
    send_pixel(make_pixel(10, 240, 10, 0, 1'b0));
    wait_drained();
  endtask

  // Frame-like runs over a pool of positions under many register settings,
  // with stray items mixed in.
  task automatic test_random_phases();
    int ph, fr, s;
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: program_all(mect_pkg::MODE_TRAIL, 0, 0, 0, 0, 0, 0, 0);
        1: program_all(MODE_SPARE, 255, 255, 255, 2047, 0, 511, 25'h1FFFFFF);
        2: program_all(mect_pkg::MODE_OVERLAY, 128, 200, 180, 1024, 255, 256,
                       {1'b1, 24'($urandom)});
        3: program_all(mect_pkg::MODE_GREY, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), 1024, $urandom_range(20), 1,
                       {1'b0, 24'($urandom)});
        default: program_all($urandom_range(3), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255),
                   ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1024),
                   ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40),
                   ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256, 1),
                   $urandom_range(25'h1FFFFFF));
      endcase
      // Some phases run with no idling at all.
      case (ph % 3)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 20; stall_pct = 20; end
        default: begin gap_pct = 40; stall_pct = 50; end
      endcase
      new_pool();
      for (fr = 0; fr < FRAMES_PER_PHASE; fr++) begin
        for (s = 0; s < POOL_SIZE; s++) begin
          if ($urandom_range(9) == 0) send_pixel(noise_pixel());
          send_pixel(scene_pixel(s, fr == 0));
        end
      end
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the pipeline fills and the input stalls.
  task automatic test_backpressure();
    int k;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_off_req = 1'b1;
    for (k = 0; k < 64; k++) begin
      send_pixel(make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                            $urandom_range(FRAME_PIXELS - 1), $urandom_range(1)));
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Clock, receiver, checker and time limit
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output stall: random idle runs, or one long hold-off on request.
  initial begin
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall    = 1'b0;
        run          = 0;
      end else if (run > 0) begin
        run--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall = 1'b1;
        run       = idle_length() - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Each accepted result against the oldest expected pixel.
  always @(posedge clk) begin : check_results
    mect_pkg::pix_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with no item outstanding, expected none, got %0d %0d %0d",
                   $time, out_data.out_y, out_data.out_u, out_data.out_v);
      end else begin
        want = expected_pixels.pop_front();
        compare_field("out_y", want.out_y, out_data.out_y);
        compare_field("out_u", want.out_u, out_data.out_u);
        compare_field("out_v", want.out_v, out_data.out_v);
      end
    end
  end

  initial begin
    #(12 * RUN_LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = mect_pkg::CFG_OUTPUT_MODE;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_data          = '0;
    error_count      = 0;
    gap_pct          = 20;
    stall_pct        = 20;
    hold_off_req     = 1'b0;
    cur_mode         = mect_pkg::RST_OUTPUT_MODE;
    cur_opacity      = mect_pkg::RST_OVERLAY_OPACITY;
    cur_trail_decay  = mect_pkg::RST_TRAIL_PERSISTENCE;
    cur_motion_decay = mect_pkg::RST_MOTION_PERSISTENCE;
    cur_gain         = mect_pkg::RST_MOTION_GAIN;
    cur_cutoff       = mect_pkg::RST_MOTION_CUTOFF;
    cur_rate         = mect_pkg::RST_ADAPTATION_RATE;
    cur_strobe       = mect_pkg::RST_STROBE_WORD;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_seeding();
    test_out_of_range();
    test_output_modes();
    test_random_phases();
    test_backpressure();

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
